// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, compiled out when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// checked on every rising edge outside reset
`define ASSERT_CLKD(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// checked on every rising edge, reset included
`define ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`else

`define ASSERT_CLKD(lbl, prop)
`define ASSERT_ALWAYS(lbl, prop)

`endif

`endif

// ----- design/pcw_pkg.sv -----
// ----------------------------------------------------------------------------
// pcw_pkg
// shared types and constants of the png chunk walker
// ----------------------------------------------------------------------------
package pcw_pkg;

  localparam int CNT_W = 33;

  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_file;
  } in_t;

  typedef struct packed {
    logic [15:0] chunk_number;
    logic [31:0] chunk_length;
    logic [31:0] chunk_type;
    logic        is_header;
    logic [31:0] image_width;
    logic [31:0] image_height;
    logic        is_end;
  } out_t;

  typedef struct packed {
    logic valid;
    out_t data;
  } res_t;

  typedef enum logic [2:0] {
    PH_SIG  = 3'd0,
    PH_HEAD = 3'd1,
    PH_IHDR = 3'd2,
    PH_SKIP = 3'd3,
    PH_DONE = 3'd4
  } phase_t;

  localparam cnt_t SIG_BYTES      = 33'd8;
  localparam cnt_t FIELD_BYTES    = 33'd4;
  localparam cnt_t HEAD_BYTES     = 33'd8;
  localparam cnt_t WH_BYTES       = 33'd8;
  localparam cnt_t IHDR_BYTES     = 33'd13;
  localparam cnt_t CRC_BYTES      = 33'd4;

  localparam logic [31:0] TYPE_IHDR = 32'h4948_4452;
  localparam logic [31:0] TYPE_IEND = 32'h4945_4E44;

  localparam logic [32:0] NUM_MAX = 33'h0_FFFF;

endpackage

// ----- design/pcw_in_stage.sv -----
// ----------------------------------------------------------------------------
// pcw_in_stage
// input register: holds one byte transaction until the parser takes it
// ----------------------------------------------------------------------------
module pcw_in_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  pcw_pkg::in_t  in_data,
  input  logic          take,
  output logic          item_valid,
  output pcw_pkg::in_t  item
);

  logic         valid_r;
  logic         valid_nxt;
  pcw_pkg::in_t data_r;

  assign in_ready   = !valid_r || take;
  assign item_valid = valid_r;
  assign item       = data_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= in_data;
    end
  end

endmodule

// ----- design/pcw_parser.sv -----
// ----------------------------------------------------------------------------
// pcw_parser
// chunk walker state: consumes one byte per step, flags a chunk report
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pcw_parser #(
  parameter int CHUNK_COUNT_BITS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step,
  input  pcw_pkg::in_t  item,
  output pcw_pkg::res_t res
);

  pcw_pkg::phase_t             phase_r, phase_nxt, cur_phase;
  pcw_pkg::cnt_t               cnt_r, cnt_nxt, cur_cnt;
  logic [31:0]                 len_r, len_nxt, cur_len;
  logic [31:0]                 type_r, type_nxt, cur_type;
  logic [31:0]                 wid_r, wid_nxt, cur_wid;
  logic [31:0]                 hgt_r, hgt_nxt, cur_hgt;
  logic [CHUNK_COUNT_BITS-1:0] count_r, count_nxt, cur_count;
  logic [32:0]                 count_wide;
  logic                        sof;
  logic [7:0]                  b;

  assign sof        = item.start_of_file;
  assign b          = item.data_byte;
  assign count_wide = 33'(count_nxt);

  always_comb begin
    cur_phase = sof ? pcw_pkg::PH_SIG : phase_r;
    cur_cnt   = sof ? '0 : cnt_r;
    cur_len   = sof ? '0 : len_r;
    cur_type  = sof ? '0 : type_r;
    cur_wid   = sof ? '0 : wid_r;
    cur_hgt   = sof ? '0 : hgt_r;
    cur_count = sof ? '0 : count_r;

    phase_nxt = cur_phase;
    cnt_nxt   = cur_cnt;
    len_nxt   = cur_len;
    type_nxt  = cur_type;
    wid_nxt   = cur_wid;
    hgt_nxt   = cur_hgt;
    count_nxt = cur_count;

    res.valid           = 1'b0;
    res.data.is_header  = 1'b0;
    res.data.is_end     = 1'b0;
    res.data.image_width  = '0;
    res.data.image_height = '0;

    unique case (cur_phase)
      pcw_pkg::PH_SIG: begin
        cnt_nxt = cur_cnt + 1'b1;
        if (cnt_nxt >= pcw_pkg::SIG_BYTES) begin
          cnt_nxt   = '0;
          phase_nxt = pcw_pkg::PH_HEAD;
        end
      end
      pcw_pkg::PH_HEAD: begin
        if (cur_cnt < pcw_pkg::FIELD_BYTES) begin
          len_nxt = {cur_len[23:0], b};
        end else begin
          type_nxt = {cur_type[23:0], b};
        end
        cnt_nxt = cur_cnt + 1'b1;
        if (cnt_nxt >= pcw_pkg::HEAD_BYTES) begin
          if (cur_count != '1) begin
            count_nxt = cur_count + 1'b1;
          end
          if (type_nxt == pcw_pkg::TYPE_IHDR) begin
            cnt_nxt   = '0;
            wid_nxt   = '0;
            hgt_nxt   = '0;
            phase_nxt = pcw_pkg::PH_IHDR;
          end else if (type_nxt == pcw_pkg::TYPE_IEND) begin
            cnt_nxt         = '0;
            phase_nxt       = pcw_pkg::PH_DONE;
            res.valid       = 1'b1;
            res.data.is_end = 1'b1;
          end else begin
            cnt_nxt   = {1'b0, len_nxt} + pcw_pkg::CRC_BYTES;
            phase_nxt = pcw_pkg::PH_SKIP;
            res.valid = 1'b1;
          end
        end
      end
      pcw_pkg::PH_IHDR: begin
        if (cur_cnt < pcw_pkg::FIELD_BYTES) begin
          wid_nxt = {cur_wid[23:0], b};
        end else if (cur_cnt < pcw_pkg::WH_BYTES) begin
          hgt_nxt = {cur_hgt[23:0], b};
        end
        cnt_nxt = cur_cnt + 1'b1;
        if (cnt_nxt >= pcw_pkg::IHDR_BYTES) begin
          cnt_nxt               = pcw_pkg::CRC_BYTES;
          phase_nxt             = pcw_pkg::PH_SKIP;
          res.valid             = 1'b1;
          res.data.is_header    = 1'b1;
          res.data.image_width  = wid_nxt;
          res.data.image_height = hgt_nxt;
        end
      end
      pcw_pkg::PH_SKIP: begin
        if (cur_cnt != '0) begin
          cnt_nxt = cur_cnt - 1'b1;
        end
        if (cnt_nxt == '0) begin
          phase_nxt = pcw_pkg::PH_HEAD;
        end
      end
      default: begin
      end
    endcase

    res.data.chunk_number = (count_wide > pcw_pkg::NUM_MAX) ? 16'hFFFF : count_wide[15:0];
    res.data.chunk_length = len_nxt;
    res.data.chunk_type   = type_nxt;
    res.valid             = res.valid && step;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= pcw_pkg::PH_SIG;
      cnt_r   <= '0;
      len_r   <= '0;
      type_r  <= '0;
      wid_r   <= '0;
      hgt_r   <= '0;
      count_r <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      len_r   <= len_nxt;
      type_r  <= type_nxt;
      wid_r   <= wid_nxt;
      hgt_r   <= hgt_nxt;
      count_r <= count_nxt;
    end
  end

  // skip count stays nonzero while skipping
  `ASSERT_CLKD(a_skip_nonzero, (phase_r == pcw_pkg::PH_SKIP) |-> (cnt_r != '0))
  // header byte index stays below eight
  `ASSERT_CLKD(a_head_cnt, (phase_r == pcw_pkg::PH_HEAD) |-> (cnt_r < pcw_pkg::HEAD_BYTES))
  // an end report parks the walker
  `ASSERT_CLKD(a_end_stops, (res.valid && res.data.is_end) |=> (phase_r == pcw_pkg::PH_DONE))
  // a header report leaves only the crc to skip
  `ASSERT_CLKD(a_hdr_crc, (res.valid && res.data.is_header) |=> (cnt_r == pcw_pkg::CRC_BYTES))

endmodule

// ----- design/pcw_out_stage.sv -----
// ----------------------------------------------------------------------------
// pcw_out_stage
// result register: holds a chunk report until the consumer takes it
// ----------------------------------------------------------------------------
module pcw_out_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  pcw_pkg::res_t res,
  output logic          space,
  output logic          out_valid,
  input  logic          out_ready,
  output pcw_pkg::out_t out_data
);

  logic          valid_r;
  logic          valid_nxt;
  pcw_pkg::out_t data_r;

  assign space     = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_comb begin
    valid_nxt = valid_r;
    if (space) begin
      valid_nxt = res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (space && res.valid) begin
      data_r <= res.data;
    end
  end

endmodule

// ----- design/png_chunk_walker_core.sv -----
// a byte accepted into the input register is parsed by a parser step, which registers its report
// throughput: one byte per cycle while the result register has space, set by the parser step between two registers
// a full result register that is not taken stalls the parser and then the input
// reset: synchronous active-low rst_n clears both valid flags and puts the walker at the
// start of the signature with a zero chunk count
// ----------------------------------------------------------------------------
// png_chunk_walker_core
// walks png chunk headers one byte per transaction and reports each chunk
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module png_chunk_walker_core #(
  parameter int CHUNK_COUNT_BITS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  pcw_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output pcw_pkg::out_t out_data
);

  logic          item_valid;
  pcw_pkg::in_t  item;
  logic          space;
  logic          step;
  pcw_pkg::res_t res;

  assign step = item_valid && space;

  pcw_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .take       (step),
    .item_valid (item_valid),
    .item       (item)
  );

  pcw_parser #(
    .CHUNK_COUNT_BITS (CHUNK_COUNT_BITS)
  ) u_parser (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .item  (item),
    .res   (res)
  );

  pcw_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res       (res),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // a report is produced only by a parser step
  `ASSERT_CLKD(a_res_step, res.valid |-> step)
  // a stalled report is not overwritten
  `ASSERT_CLKD(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
  // the parser never steps on an empty input register
  `ASSERT_CLKD(a_no_step_empty, step |-> item_valid)

endmodule
